/* design/tpc_pkg.sv */
package tpc_pkg;

   localparam int COORD_W  = 24;
   localparam int NORM_W   = 16;
   localparam int OFF_W    = 25;
   localparam int CSR_W    = 25;
   localparam int PROD_W   = NORM_W + COORD_W;
   localparam int DIST_W   = PROD_W + 3;
   localparam int ALPHA_W  = 17;
   localparam int DIV_LAT  = ALPHA_W + 1;
   localparam int DIST_LAT = 2;
   localparam int LERP_LAT = 2;
   localparam int LINE_LEN = DIST_LAT + DIV_LAT + LERP_LAT;

   localparam logic [2:0] CSR_NX    = 3'd0;
   localparam logic [2:0] CSR_NY    = 3'd1;
   localparam logic [2:0] CSR_NZ    = 3'd2;
   localparam logic [2:0] CSR_OFF   = 3'd3;
   localparam logic [2:0] CSR_OTHER = 3'd4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIST_W-1:0]  dist_type;
   typedef logic [ALPHA_W-1:0]        alpha_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vtx_type;

   typedef struct packed {
      logic    side;
      vtx_type p0;
      vtx_type p1;
      vtx_type p2;
   } tri_type;

   typedef struct packed {
      logic              valid;
      logic [2:0]        kept;
      vtx_type [2:0]     v;
   } line_type;

endpackage

/* design/tpc_if.sv */
interface tpc_req_if;
   logic valid;
   logic ready;
   logic signed [23:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tpc_rsp_if;
   logic valid;
   logic ready;
   logic side;
   logic signed [23:0] p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
   logic last_triangle;
   modport source (output valid, side, p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z,
                   last_triangle, input ready);
   modport sink (input valid, side, p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z,
                 last_triangle, output ready);
endinterface

/* design/tpc_dist.sv */
module tpc_dist (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [tpc_pkg::NORM_W-1:0]  nx,
   input  logic signed [tpc_pkg::NORM_W-1:0]  ny,
   input  logic signed [tpc_pkg::NORM_W-1:0]  nz,
   input  logic signed [tpc_pkg::OFF_W-1:0]   offset,
   input  tpc_pkg::vtx_type [2:0]              verts,
   output tpc_pkg::dist_type                   dist_out [3]
);
   localparam int PW = tpc_pkg::PROD_W;
   localparam int DW = tpc_pkg::DIST_W;

   logic signed [PW-1:0] px_ff [3], py_ff [3], pz_ff [3];
   logic signed [PW-1:0] px_in [3], py_in [3], pz_in [3];
   tpc_pkg::dist_type    dist_ff [3], dist_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         px_in[i] = PW'(nx) * PW'(verts[i].x);
         py_in[i] = PW'(ny) * PW'(verts[i].y);
         pz_in[i] = PW'(nz) * PW'(verts[i].z);
         dist_in[i] = DW'(px_ff[i]) + DW'(py_ff[i]) + DW'(pz_ff[i]) - (DW'(offset) <<< 14);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         dist_ff <= dist_in;
      end
   end

   assign dist_out = dist_ff;
endmodule

/* design/tpc_div.sv */
module tpc_div (
   input  logic               clock,
   input  logic               enable,
   input  tpc_pkg::dist_type  dt,
   input  tpc_pkg::dist_type  du,
   output tpc_pkg::alpha_type alpha
);
   localparam int DW = tpc_pkg::DIST_W;
   localparam int QW = tpc_pkg::ALPHA_W;
   localparam int NW = DW + 17;

   logic [DW:0]   rem_ff [QW+1], den_ff [QW+1];
   logic [QW-1:0] low_ff [QW+1], q_ff [QW+1];
   logic [DW-1:0] num, mu;
   logic [DW:0]   den;
   logic [NW-1:0] n_full;

   // magnitudes, then numerator scaled with a half-denominator bias for rounding
   always_comb begin
      num    = dt[DW-1] ? DW'(-dt) : DW'(dt);
      mu     = du[DW-1] ? DW'(-du) : DW'(du);
      den    = {1'b0, num} + {1'b0, mu};
      n_full = {1'b0, num, 16'b0} + NW'(den >> 1);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {1'b0, n_full[NW-1:QW]};
         den_ff[0] <= den;
         low_ff[0] <= n_full[QW-1:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_step
      logic [DW+1:0] trial;
      logic          ge;
      always_comb begin
         trial = {rem_ff[s-1], low_ff[s-1][QW-1]};
         ge    = trial >= {1'b0, den_ff[s-1]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= ge ? (DW+1)'(trial - {1'b0, den_ff[s-1]}) : (DW+1)'(trial);
            den_ff[s] <= den_ff[s-1];
            low_ff[s] <= {low_ff[s-1][QW-2:0], 1'b0};
            q_ff[s]   <= {q_ff[s-1][QW-2:0], ge};
         end
      end
   end

   assign alpha = q_ff[QW];
endmodule

/* design/tpc_lerp.sv */
module tpc_lerp (
   input  logic                  clock,
   input  logic                  enable,
   input  tpc_pkg::vtx_type [2:0] verts,
   input  tpc_pkg::alpha_type    alpha [3],
   output tpc_pkg::vtx_type      point [3]
);
   localparam int CW = tpc_pkg::COORD_W;
   localparam int MW = CW + 1 + tpc_pkg::ALPHA_W + 1;

   logic signed [MW-1:0] prod_ff [3][3], prod_in [3][3];
   tpc_pkg::vtx_type     t_ff [3];
   tpc_pkg::vtx_type     point_ff [3], point_in [3];

   function automatic logic signed [MW-1:0] scale(input tpc_pkg::coord_type t,
                                                  input tpc_pkg::coord_type u,
                                                  input tpc_pkg::alpha_type a);
      logic signed [CW:0] diff;
      diff  = (CW+1)'(u) - (CW+1)'(t);
      return MW'(diff) * MW'(signed'({1'b0, a}));
   endfunction

   function automatic tpc_pkg::coord_type finish(input tpc_pkg::coord_type t,
                                                 input logic signed [MW-1:0] p);
      logic signed [MW:0]   biased;
      logic signed [CW+3:0] sum;
      biased = (MW+1)'(p) + (MW+1)'(32768);
      sum    = (CW+4)'(biased >>> 16) + (CW+4)'(t);
      return sum[CW-1:0];
   endfunction

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         prod_in[e][0] = scale(verts[e].x, verts[(e+1)%3].x, alpha[e]);
         prod_in[e][1] = scale(verts[e].y, verts[(e+1)%3].y, alpha[e]);
         prod_in[e][2] = scale(verts[e].z, verts[(e+1)%3].z, alpha[e]);
         point_in[e].x = finish(t_ff[e].x, prod_ff[e][0]);
         point_in[e].y = finish(t_ff[e].y, prod_ff[e][1]);
         point_in[e].z = finish(t_ff[e].z, prod_ff[e][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= prod_in;
         point_ff <= point_in;
         for (int e = 0; e < 3; e++) t_ff[e] <= verts[e];
      end
   end

   assign point = point_ff;
endmodule

/* design/tpc_emit.sv */
module tpc_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0]            kept,
   input  tpc_pkg::vtx_type [2:0] verts,
   input  tpc_pkg::vtx_type      point [3],
   input  logic                  keep_other,
   output logic                  advance,
   tpc_rsp_if.source             rsp
);
   tpc_pkg::tri_type tri_ff [3], tri_in [3];
   logic [1:0]       cnt_ff, cnt_in, idx_ff;
   logic             hold_ff;
   logic             last;

   // walk the edges, split vertices into the two polygons, then fan them out (the negative one only with keep_other)
   always_comb begin
      tpc_pkg::vtx_type pos [4];
      tpc_pkg::vtx_type neg [4];
      logic [2:0] np, nn;
      logic [1:0] cnt;
      for (int i = 0; i < 4; i++) begin
         pos[i] = '0;
         neg[i] = '0;
      end
      for (int i = 0; i < 3; i++) tri_in[i] = '0;
      np  = '0;
      nn  = '0;
      cnt = '0;
      for (int i = 0; i < 3; i++) begin
         if (kept[i]) begin
            pos[np[1:0]] = verts[i];
            np = np + 3'd1;
         end else begin
            neg[nn[1:0]] = verts[i];
            nn = nn + 3'd1;
         end
         if (kept[i] != kept[(i+1)%3]) begin
            pos[np[1:0]] = point[i];
            neg[nn[1:0]] = point[i];
            np = np + 3'd1;
            nn = nn + 3'd1;
         end
      end
      for (int t = 2; t < 4; t++) begin
         if (3'(t) < np) begin
            tri_in[cnt] = '{1'b0, pos[0], pos[t-1], pos[t]};
            cnt = cnt + 2'd1;
         end
      end
      for (int t = 2; t < 4; t++) begin
         if (keep_other && 3'(t) < nn) begin
            tri_in[cnt] = '{1'b1, neg[0], neg[t-1], neg[t]};
            cnt = cnt + 2'd1;
         end
      end
      cnt_in = cnt;
   end

   assign last    = idx_ff == cnt_ff - 2'd1;
   assign advance = !hold_ff || (rsp.ready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (advance) begin
         hold_ff <= in_valid && cnt_in != 2'd0;
         idx_ff  <= '0;
      end else if (rsp.ready) begin
         idx_ff  <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tri_ff <= tri_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      rsp.valid         = hold_ff;
      rsp.side          = tri_ff[idx_ff].side;
      rsp.p0x           = tri_ff[idx_ff].p0.x;
      rsp.p0y           = tri_ff[idx_ff].p0.y;
      rsp.p0z           = tri_ff[idx_ff].p0.z;
      rsp.p1x           = tri_ff[idx_ff].p1.x;
      rsp.p1y           = tri_ff[idx_ff].p1.y;
      rsp.p1z           = tri_ff[idx_ff].p1.z;
      rsp.p2x           = tri_ff[idx_ff].p2.x;
      rsp.p2y           = tri_ff[idx_ff].p2.y;
      rsp.p2z           = tri_ff[idx_ff].p2.z;
      rsp.last_triangle = last;
   end

`ifndef SYNTHESIS
   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (cnt_ff != 2'd0 && idx_ff < cnt_ff))
      else $error("held item with bad triangle index");
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !advance |-> hold_ff)
      else $error("pipeline stalled with empty output");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (hold_ff && rsp.ready && !last) |=> (hold_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("triangle index did not advance");
`endif
endmodule

/* design/triangle_plane_clipper.sv */
// channel    dir  handshake               payload
// req_chan   in   valid/ready             ax..cz, three vertices Q15.8
// rsp_chan   out  valid/ready             side, p0x..p2z, last_triangle
// csr_*      in   csr_we, no back-pressure plane normal, offset, keep_other_half
//
// One transaction enters per cycle while the pipeline advances; its first result reaches
// rsp_chan through 23 register stages (2 distance, 18 alpha divider, 2 interpolation,
// output register).
// An input that yields two or three triangles holds the input side until the single output
// register has emitted them, one triangle per cycle while rsp_chan.ready is high.
// reset is synchronous: it clears valid bits and the output hold flag and loads the plane
// registers with their reset values.
// rsp_chan.ready low while a triangle waits freezes every stage in place; nothing is lost
// or repeated.
module triangle_plane_clipper (
   input  logic                         clock,
   input  logic                         reset,
   tpc_req_if.sink                      req_chan,
   tpc_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [tpc_pkg::CSR_W-1:0]    csr_wdata
);
   localparam int LL = tpc_pkg::LINE_LEN;

   logic signed [tpc_pkg::NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [tpc_pkg::OFF_W-1:0]  off_ff;
   logic                              other_ff;
   logic                              advance;

   tpc_pkg::line_type  head_in;
   tpc_pkg::line_type  line_ff [1:LL];
   tpc_pkg::dist_type  vtx_dist [3];
   tpc_pkg::alpha_type alpha [3];
   tpc_pkg::vtx_type   point [3];
   logic [2:0]         kept;

   // plane registers: the user writes them only while the pipeline is drained; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff    <= '0;
         ny_ff    <= '0;
         nz_ff    <= 16'sd16384;
         off_ff   <= '0;
         other_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tpc_pkg::CSR_NX:    nx_ff    <= csr_wdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::CSR_NY:    ny_ff    <= csr_wdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::CSR_NZ:    nz_ff    <= csr_wdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::CSR_OFF:   off_ff   <= csr_wdata[tpc_pkg::OFF_W-1:0];
            tpc_pkg::CSR_OTHER: other_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = advance;

   // present the incoming transaction at the head of the delay line
   always_comb begin
      head_in.valid  = req_chan.valid;
      head_in.kept   = '0;
      head_in.v[0]   = '{req_chan.ax, req_chan.ay, req_chan.az};
      head_in.v[1]   = '{req_chan.bx, req_chan.by_coord, req_chan.bz};
      head_in.v[2]   = '{req_chan.cx, req_chan.cy, req_chan.cz};
   end

   // a vertex is kept on a strictly positive distance
   always_comb begin
      for (int i = 0; i < 3; i++)
         kept[i] = !vtx_dist[i][tpc_pkg::DIST_W-1] && vtx_dist[i] != '0;
   end

   // vertices, valid and kept bits ride alongside the arithmetic stages
   for (genvar k = 1; k <= LL; k++) begin : g_line
      tpc_pkg::line_type prev;
      if (k == 1) begin : g_first
         assign prev = head_in;
      end else begin : g_next
         assign prev = line_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            line_ff[k].valid <= 1'b0;
         end else if (advance) begin
            line_ff[k].valid <= prev.valid;
         end
         if (advance) begin
            line_ff[k].v    <= prev.v;
            line_ff[k].kept <= (k == tpc_pkg::DIST_LAT + 1) ? kept : prev.kept;
         end
      end
   end

   tpc_dist u_dist (
      .clock    (clock),
      .enable   (advance),
      .nx       (nx_ff),
      .ny       (ny_ff),
      .nz       (nz_ff),
      .offset   (off_ff),
      .verts    (head_in.v),
      .dist_out (vtx_dist)
   );

   // one divider per edge; edge e runs from vertex e to the next vertex in winding order
   for (genvar e = 0; e < 3; e++) begin : g_edge
      tpc_div u_div (
         .clock  (clock),
         .enable (advance),
         .dt     (vtx_dist[e]),
         .du     (vtx_dist[(e+1)%3]),
         .alpha  (alpha[e])
      );
   end

   tpc_lerp u_lerp (
      .clock  (clock),
      .enable (advance),
      .verts  (line_ff[tpc_pkg::DIST_LAT + tpc_pkg::DIV_LAT].v),
      .alpha  (alpha),
      .point  (point)
   );

   tpc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (line_ff[LL].valid),
      .kept       (line_ff[LL].kept),
      .verts      (line_ff[LL].v),
      .point      (point),
      .keep_other (other_ff),
      .advance    (advance),
      .rsp        (rsp_chan)
   );
endmodule

/* bench/testbench.sv */
module testbench;

   typedef struct {
      logic                side;
      tpc_pkg::coord_type  c [9];
      logic                last;
   } exp_tri_type;

   typedef struct {
      tpc_pkg::coord_type  c [9];
      bit                  has_exp;
      int                  exp_count;
      logic                exp_side;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = tpc_pkg::CSR_NX;
   logic [tpc_pkg::CSR_W-1:0] csr_wdata = '0;

   tpc_req_if req_chan ();
   tpc_rsp_if rsp_chan ();

   triangle_plane_clipper dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow copy of the plane registers used by the predictor
   logic signed [tpc_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;
   logic signed [tpc_pkg::OFF_W-1:0]  plane_off;
   logic                              other_on;

   exp_tri_type  expected_tris [$];
   int           error_count = 0;
   int           row_errors = 0;
   int           tri_seen = 0;
   int           split_seen = 0;
   int           cycle_count = 0;
   bit           no_idle = 1'b0;
   int           idle_pct = 35;
   stim_row_type rows [$];

   // cycle limit: generous bound on the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint vdist(tpc_pkg::coord_type p [3]);
      return longint'(norm_x) * p[0] + longint'(norm_y) * p[1] + longint'(norm_z) * p[2]
             - longint'(plane_off) * 16384;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // rounded shift by 16, halves toward plus infinity
   function automatic longint rnd16(longint prod);
      longint t;
      t = prod + 32768;
      return t >>> 16;
   endfunction

   task automatic edge_cross(input tpc_pkg::coord_type t [3], input tpc_pkg::coord_type u [3],
                             input longint dt, input longint du,
                             output tpc_pkg::coord_type r [3]);
      longint num, den, alpha;
      num = abs64(dt);
      den = num + abs64(du);
      alpha = (num * 65536 + den / 2) / den;
      if (alpha > 65536) alpha = 65536;
      for (int k = 0; k < 3; k++)
         r[k] = tpc_pkg::coord_type'(longint'(t[k]) + rnd16((longint'(u[k]) - t[k]) * alpha));
   endtask

   task automatic push_tri(input logic side, input tpc_pkg::coord_type a [3],
                           input tpc_pkg::coord_type b [3], input tpc_pkg::coord_type c [3]);
      exp_tri_type r;
      r.side = side;
      for (int k = 0; k < 3; k++) begin
         r.c[k] = a[k];
         r.c[3 + k] = b[k];
         r.c[6 + k] = c[k];
      end
      r.last = 1'b0;
      expected_tris.push_back(r);
   endtask

   // predict the triangles that one input triangle yields; returns how many
   task automatic clip_triangle(input tpc_pkg::coord_type c [9], output int count);
      tpc_pkg::coord_type v [3][3];
      tpc_pkg::coord_type pos [4][3];
      tpc_pkg::coord_type neg [4][3];
      tpc_pkg::coord_type x [3];
      longint d [3];
      bit kept [3];
      int np, nn, j;
      np = 0;
      nn = 0;
      count = 0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) v[i][k] = c[i * 3 + k];
         d[i] = vdist(v[i]);
         kept[i] = d[i] > 0;
      end
      if (kept[0] && kept[1] && kept[2]) begin
         push_tri(1'b0, v[0], v[1], v[2]);
         count = 1;
      end else if (!kept[0] && !kept[1] && !kept[2]) begin
         if (other_on) begin
            push_tri(1'b1, v[0], v[1], v[2]);
            count = 1;
         end
      end else begin
         split_seen++;
         for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            if (kept[i]) pos[np++] = v[i];
            else neg[nn++] = v[i];
            if (kept[i] != kept[j]) begin
               edge_cross(v[i], v[j], d[i], d[j], x);
               pos[np++] = x;
               neg[nn++] = x;
            end
         end
         for (int i = 2; i < np; i++) begin
            push_tri(1'b0, pos[0], pos[i - 1], pos[i]);
            count++;
         end
         if (other_on)
            for (int i = 2; i < nn; i++) begin
               push_tri(1'b1, neg[0], neg[i - 1], neg[i]);
               count++;
            end
      end
      if (count > 0) expected_tris[$].last = 1'b1;
   endtask

   task automatic write_csr(input logic [2:0] idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= tpc_pkg::CSR_W'(value);
      case (idx)
         tpc_pkg::CSR_NX:    norm_x = tpc_pkg::NORM_W'(value);
         tpc_pkg::CSR_NY:    norm_y = tpc_pkg::NORM_W'(value);
         tpc_pkg::CSR_NZ:    norm_z = tpc_pkg::NORM_W'(value);
         tpc_pkg::CSR_OFF:   plane_off = tpc_pkg::OFF_W'(value);
         tpc_pkg::CSR_OTHER: other_on = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_plane(input longint nx, input longint ny, input longint nz,
                            input longint off, input bit other);
      write_csr(tpc_pkg::CSR_NX, nx);
      write_csr(tpc_pkg::CSR_NY, ny);
      write_csr(tpc_pkg::CSR_NZ, nz);
      write_csr(tpc_pkg::CSR_OFF, off);
      write_csr(tpc_pkg::CSR_OTHER, other);
   endtask

   // hold until every expected triangle has drained, then let the pipe settle
   task automatic drain_wait();
      while (expected_tris.size() != 0) @(posedge clock);
      repeat (tpc_pkg::LINE_LEN + 8) @(posedge clock);
   endtask

   // send one transaction; the valid stays up across back-to-back items
   task automatic send_tri(input tpc_pkg::coord_type c [9], output int count);
      while (!no_idle && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ax <= c[0]; req_chan.ay <= c[1]; req_chan.az <= c[2];
      req_chan.bx <= c[3]; req_chan.by_coord <= c[4]; req_chan.bz <= c[5];
      req_chan.cx <= c[6]; req_chan.cy <= c[7]; req_chan.cz <= c[8];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      clip_triangle(c, count);
   endtask

   task automatic stop_send();
      req_chan.valid <= 1'b0;
   endtask

   // random stall on the result side, with a stretch of full throughput
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= idle_pct);
   end

   // compare every accepted result against the oldest expected triangle
   always @(posedge clock) begin
      exp_tri_type e;
      tpc_pkg::coord_type got [9];
      bit bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.p0x, rsp_chan.p0y, rsp_chan.p0z, rsp_chan.p1x, rsp_chan.p1y,
                 rsp_chan.p1z, rsp_chan.p2x, rsp_chan.p2y, rsp_chan.p2z};
         tri_seen++;
         if (expected_tris.size() == 0) begin
            error_count++;
            if (error_count + row_errors <= 10)
               $display("unexpected result triangle side=%0d", rsp_chan.side);
         end else begin
            e = expected_tris.pop_front();
            bad = (e.side !== rsp_chan.side) || (e.last !== rsp_chan.last_triangle);
            for (int k = 0; k < 9; k++) if (e.c[k] !== got[k]) bad = 1'b1;
            if (bad) begin
               error_count++;
               if (error_count + row_errors <= 10) begin
                  $display("mismatch: exp side=%0d last=%0d %p", e.side, e.last, e.c);
                  $display("          got side=%0d last=%0d %p", rsp_chan.side,
                           rsp_chan.last_triangle, got);
               end
            end
         end
      end
   end

   function automatic tpc_pkg::coord_type rnd_coord(int span);
      if (span == 0) return tpc_pkg::coord_type'($urandom);
      return tpc_pkg::coord_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic stim_row_type mk(tpc_pkg::coord_type c [9]);
      stim_row_type r;
      r.c = c;
      r.has_exp = 1'b0;
      r.exp_count = 0;
      r.exp_side = 1'b0;
      return r;
   endfunction

   // walk a table of rows; rows with typed-in expectations are checked for count and side
   task automatic run_rows();
      int got_count;
      foreach (rows[i]) begin
         send_tri(rows[i].c, got_count);
         if (rows[i].has_exp && (got_count != rows[i].exp_count
             || (rows[i].exp_count > 0 && expected_tris[$].side != rows[i].exp_side))) begin
            row_errors++;
            if (error_count + row_errors <= 10)
               $display("directed row %0d: wrong triangle count", i);
         end
      end
      stop_send();
      rows.delete();
   endtask

   initial begin
      tpc_pkg::coord_type c [9];
      tpc_pkg::coord_type mx, mn;
      stim_row_type r;
      int n_out;
      req_chan.valid = 1'b0;
      {req_chan.ax, req_chan.ay, req_chan.az} = '0;
      {req_chan.bx, req_chan.by_coord, req_chan.bz} = '0;
      {req_chan.cx, req_chan.cy, req_chan.cz} = '0;
      mx = 24'sh7FFFFF;
      mn = -24'sh800000;
      norm_x = 0; norm_y = 0; norm_z = 16384; plane_off = 0; other_on = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset plane is z = 0: all above, all below (dropped), all vertices on the plane
      r = mk('{0, 0, 256, 256, 0, 256, 0, 256, 256});
      r.has_exp = 1; r.exp_count = 1; r.exp_side = 0; rows.push_back(r);
      r = mk('{0, 0, -256, 256, 0, -256, 0, 256, -256});
      r.has_exp = 1; r.exp_count = 0; rows.push_back(r);
      r = mk('{0, 0, 0, 256, 0, 0, 0, 256, 0});
      r.has_exp = 1; r.exp_count = 0; rows.push_back(r);
      rows.push_back(mk('{0, 0, 256, 256, 0, -256, 0, 256, -256}));
      rows.push_back(mk('{0, 0, -256, 256, 0, 256, 0, 256, 256}));
      rows.push_back(mk('{mx, mx, mx, mn, mn, mn, mx, mn, 0}));
      rows.push_back(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      run_rows();
      drain_wait();

      // other half on, extreme normal components and offset
      set_plane(-16384, 16384, -16384, 24'sh7FFFFF, 1);
      rows.push_back(mk('{mx, mn, mn, mn, mx, mx, 0, 0, 0}));
      rows.push_back(mk('{mn, mx, mn, mx, mn, mx, mx, mx, mn}));
      rows.push_back(mk('{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
      rows.push_back(mk('{mx, mx, mx, 0, 0, 0, mn, mn, mn}));
      run_rows();
      drain_wait();
      set_plane(16384, 0, 0, -25'sd16777216, 1);
      r = mk('{mn, 0, 0, mn, 1, 0, mn, 0, 1});
      r.has_exp = 1; r.exp_count = 1; r.exp_side = 0; rows.push_back(r);
      rows.push_back(mk('{mx, mn, 0, mn, mx, 0, 0, 0, mx}));
      run_rows();
      drain_wait();
      set_plane(16384, 0, 0, 0, 1);
      r = mk('{-256, 0, 0, -256, 256, 0, -512, 0, 256});
      r.has_exp = 1; r.exp_count = 1; r.exp_side = 1; rows.push_back(r);
      rows.push_back(mk('{256, 0, 0, -256, 0, 0, 0, 256, 0}));
      rows.push_back(mk('{-256, 0, 0, 256, 7, 0, 256, 256, 3}));
      rows.push_back(mk('{0, 0, 0, 256, 0, 0, 512, 0, 0}));
      run_rows();
      drain_wait();

      // random phases: well-scattered planes, triangles straddling them
      for (int ph = 0; ph < 6; ph++) begin
         set_plane($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                   $urandom_range(32768) - 16384,
                   (ph == 5) ? longint'($urandom) : longint'($urandom_range(4096)) - 2048,
                   ph % 2);
         no_idle = (ph == 3);
         for (int n = 0; n < 35; n++) begin
            for (int k = 0; k < 9; k++)
               c[k] = rnd_coord(ph == 4 ? 0 : (n % 4 == 0 ? 0 : 4096));
            send_tri(c, n_out);
         end
         stop_send();
         drain_wait();
      end
      no_idle = 1'b0;

      $display("ran %0d result triangles, %0d inputs split by the plane", tri_seen, split_seen);
      $display("planes: reset, axis-aligned, extreme and random; other half on and off");
      if (error_count == 0 && row_errors == 0 && expected_tris.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
